// ===== rtl/hce_pkg.sv =====
// ----------------------------------------------------------------------------
// hce_pkg: shared types and constants for the chunked transfer encoder
// Item formats, framing constants and the hex digit encoder.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned COUNT_W     = 4;

  localparam logic [15:0] CHUNK_CAP  = 16'h8000;
  localparam logic [7:0]  ASCII_CR   = 8'h0d;
  localparam logic [7:0]  ASCII_LF   = 8'h0a;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [15:0] avail;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Byte 0 goes out first.
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]          count;
  } frame_t;

  typedef struct packed {
    logic [15:0] chunk_remaining;
    logic        stream_done;
  } enc_state_t;

  // Lowercase ASCII hex digit.
  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = ASCII_ZERO + {4'd0, d};
    end else begin
      r = 8'h57 + {4'd0, d};
    end
    return r;
  endfunction

endpackage

// ===== rtl/hce_framer.sv =====
// ----------------------------------------------------------------------------
// hce_framer: builds the output frame for one input transaction
// Computes chunk length, header bytes, trailer and the next encoder state.
// ----------------------------------------------------------------------------
module hce_framer
  import hce_pkg::*;
(
  input  in_item_t    item,
  input  enc_state_t  state,
  input  logic [15:0] max_chunk_len,
  output frame_t      frame,
  output enc_state_t  state_next
);

  logic [15:0] cap;
  logic [15:0] len;
  logic [15:0] avail_eff;
  logic [15:0] base;
  logic [15:0] rem_after;

  always_comb begin
    if (max_chunk_len == 16'd0) begin
      cap = 16'd1;
    end else if (max_chunk_len > CHUNK_CAP) begin
      cap = CHUNK_CAP;
    end else begin
      cap = max_chunk_len;
    end
    avail_eff = (item.avail == 16'd0) ? 16'd1 : item.avail;
    len       = (avail_eff > cap) ? cap : avail_eff;
    base      = (state.chunk_remaining == 16'd0) ? len : state.chunk_remaining;
    rem_after = base - 16'd1;
  end

  always_comb begin
    frame      = '0;
    state_next = state;
    if (state.stream_done) begin
      // drop everything after the terminator
      frame.count = '0;
    end else if (item.func == FUNC_END) begin
      frame.bytes[0] = ASCII_ZERO;
      frame.bytes[1] = ASCII_CR;
      frame.bytes[2] = ASCII_LF;
      frame.bytes[3] = ASCII_CR;
      frame.bytes[4] = ASCII_LF;
      frame.count    = COUNT_W'(5);
      state_next.chunk_remaining = '0;
      state_next.stream_done     = 1'b1;
    end else if (state.chunk_remaining == 16'd0) begin
      frame.bytes[0] = hex_digit(len[15:12]);
      frame.bytes[1] = hex_digit(len[11:8]);
      frame.bytes[2] = hex_digit(len[7:4]);
      frame.bytes[3] = hex_digit(len[3:0]);
      frame.bytes[4] = ASCII_CR;
      frame.bytes[5] = ASCII_LF;
      frame.bytes[6] = item.data_byte;
      if (rem_after == 16'd0) begin
        frame.bytes[7] = ASCII_CR;
        frame.bytes[8] = ASCII_LF;
        frame.count    = COUNT_W'(9);
      end else begin
        frame.count    = COUNT_W'(7);
      end
      state_next.chunk_remaining = rem_after;
    end else begin
      frame.bytes[0] = item.data_byte;
      if (rem_after == 16'd0) begin
        frame.bytes[1] = ASCII_CR;
        frame.bytes[2] = ASCII_LF;
        frame.count    = COUNT_W'(3);
      end else begin
        frame.count    = COUNT_W'(1);
      end
      state_next.chunk_remaining = rem_after;
    end
  end

endmodule

// ===== rtl/hce_serializer.sv =====
// ----------------------------------------------------------------------------
// hce_serializer: result register that shifts a frame out byte by byte
// Takes a new frame in the cycle its last byte is taken.
// ----------------------------------------------------------------------------
module hce_serializer
  import hce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  frame_t    frame,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [FRAME_BYTES-1:0][7:0] bytes;
  logic [COUNT_W-1:0]          cnt;
  logic                        take;

  assign out_valid        = (cnt != '0);
  assign take             = out_valid && out_ready;
  assign free             = !out_valid || (take && (cnt == COUNT_W'(1)));
  assign out_item.out_byte = bytes[0];
  assign out_item.last     = (cnt == COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= frame.count;
    end else if (take) begin
      cnt <= cnt - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= frame.bytes;
    end else if (take) begin
      bytes <= {8'h00, bytes[FRAME_BYTES-1:1]};
    end
  end

endmodule

// ===== rtl/http_chunked_encoder_core.sv =====
// ----------------------------------------------------------------------------
// http_chunked_encoder_core: HTTP/1.1 chunked transfer coding framer
// Wraps a byte stream into chunks with a four-digit hex header and CR LF
// trailer, and closes the stream with the zero-length terminator.
// ----------------------------------------------------------------------------
//
//   channel | signals                          | transaction
//   --------+----------------------------------+--------------------------------
//   in      | in_valid, in_ready, in_item      | one payload byte or end marker
//   out     | out_valid, out_ready, out_item   | one byte of the coded stream
//   cfg     | cfg_valid, cfg_ready, cfg_data   | write of max_chunk_len
//
// An input transaction yields 0 to 9 output bytes, one per cycle unless out
// stalls. Inside a chunk a byte passes straight through at one transaction per
// cycle while out does not stall; a chunk header adds 6 bytes, a trailer 2, and
// the terminator is 5 bytes in all. The output shift register sets that rate.
// Reset (rst, synchronous) closes any chunk, clears the end flag and sets
// max_chunk_len to 0x8000. The config port is always ready.
// Back-pressure on out stalls the input register, then in_ready.
// ----------------------------------------------------------------------------
module http_chunked_encoder_core
  import hce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // input register (skid stage between the two sides)
  in_item_t    item_q;
  logic        item_full;

  // encoder state and configuration
  enc_state_t  state;
  enc_state_t  state_next;
  logic [15:0] max_chunk_len;

  frame_t      frame;
  logic        ser_free;
  logic        consume;
  logic        load;

  assign cfg_ready = 1'b1;

  hce_framer u_framer (
    .item          (item_q),
    .state         (state),
    .max_chunk_len (max_chunk_len),
    .frame         (frame),
    .state_next    (state_next)
  );

  // Retire the held transaction once the serializer can take its frame;
  // a transaction that yields nothing retires at once.
  assign consume  = item_full && ((frame.count == '0) || ser_free);
  assign load     = consume && (frame.count != '0);
  assign in_ready = !item_full || consume;

  hce_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .frame     (frame),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Hold the item until the framer retires it.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_full <= 1'b1;
    end else if (consume) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

  // Advance the chunk state with each retired transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_len <= CHUNK_CAP;
    end else if (cfg_valid && cfg_ready) begin
      max_chunk_len <= cfg_data;
    end
  end

endmodule

// ===== bench/chunk_coding_checker.sv =====
// ----------------------------------------------------------------------------
// chunk_coding_checker: scoreboard for the chunked transfer encoder
// Watches the config, input and output channels. It keeps its own copy of
// the encoder state and of max_chunk_len, works out the coded bytes for each
// input transaction, and compares every output transaction with the oldest
// expected byte.
// ----------------------------------------------------------------------------
module chunk_coding_checker
  import hce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output logic        chunk_open
);

  logic [15:0] max_len;
  logic [15:0] bytes_owed;
  logic        terminated;
  out_item_t   coded_q[$];
  out_item_t   oldest;

  initial begin
    mismatches = 0;
    pending    = 0;
    chunk_open = 1'b0;
    max_len    = CHUNK_CAP;
    bytes_owed = '0;
    terminated = 1'b0;
  end

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    // lowercase: 'a' is 8'h61
    return (nib > 4'd9) ? 8'h61 + 8'(nib) - 8'd10 : ASCII_ZERO + 8'(nib);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] coded stream error: %s", $time, what);
  endtask

  task automatic predict_coded_bytes(input in_item_t it);
    logic [7:0]  seq[$];
    logic [15:0] cap;
    logic [15:0] len;
    if (terminated) return;
    if (it.func == FUNC_END) begin
      // abandon any open chunk, emit the terminator
      bytes_owed = '0;
      terminated = 1'b1;
      seq.push_back(ASCII_ZERO);
      seq.push_back(ASCII_CR);
      seq.push_back(ASCII_LF);
      seq.push_back(ASCII_CR);
      seq.push_back(ASCII_LF);
    end else begin
      if (bytes_owed == '0) begin
        cap = (max_len == '0) ? 16'd1 : max_len;
        if (cap > CHUNK_CAP) cap = CHUNK_CAP;
        len = (it.avail == '0) ? 16'd1 : it.avail;
        if (len > cap) len = cap;
        bytes_owed = len;
        seq.push_back(ascii_hex(len[15:12]));
        seq.push_back(ascii_hex(len[11:8]));
        seq.push_back(ascii_hex(len[7:4]));
        seq.push_back(ascii_hex(len[3:0]));
        seq.push_back(ASCII_CR);
        seq.push_back(ASCII_LF);
      end
      seq.push_back(it.data_byte);
      bytes_owed = bytes_owed - 16'd1;
      if (bytes_owed == '0) begin
        seq.push_back(ASCII_CR);
        seq.push_back(ASCII_LF);
      end
    end
    foreach (seq[i]) begin
      coded_q.push_back('{out_byte: seq[i], last: (i == seq.size() - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      max_len    = CHUNK_CAP;
      bytes_owed = '0;
      terminated = 1'b0;
      coded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_len = cfg_data;
      if (in_valid && in_ready) predict_coded_bytes(in_item);
      if (out_valid && out_ready) begin
        if (coded_q.size() == 0) begin
          report_mismatch($sformatf("byte %h arrived with nothing expected",
                                    out_item.out_byte));
        end else begin
          oldest = coded_q.pop_front();
          if (out_item.out_byte !== oldest.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_item.out_byte, oldest.out_byte));
          if (out_item.last !== oldest.last)
            report_mismatch($sformatf("last %b on byte %h, expected %b",
                                      out_item.last, out_item.out_byte, oldest.last));
        end
      end
    end
    pending    = coded_q.size();
    chunk_open = (bytes_owed != '0);
  end

endmodule

// ===== bench/http_chunked_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// http_chunked_encoder_core_tb: testbench for the chunked transfer encoder
// Drives config writes and input transactions with random gaps, stalls the
// output at random, and lets chunk_coding_checker predict and compare the
// coded stream. A short directed part comes first, then random traffic over
// several chunk length limits, a clamped full-size chunk header, and the
// stream terminator.
// ----------------------------------------------------------------------------
module http_chunked_encoder_core_tb;
  import hce_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int          mismatches;
  int          pending;
  logic        chunk_open;

  // Gap rates in percent; changed per traffic phase.
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 82;

  // Effective chunk cap of the current setting, used only to shape avail.
  logic [15:0] cap_now = CHUNK_CAP;

  http_chunked_encoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  chunk_coding_checker coding_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .chunk_open (chunk_open)
  );

  always #4 clk = ~clk;

  // Receiver: drop ready at random, redrawn every cycle on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hard stop in case the block hangs or never drains.
  initial begin
    #(64'd8 * 64'd2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_item_t data_item(input logic [15:0] avail, input logic [7:0] b);
    in_item_t it;
    it.func      = FUNC_DATA;
    it.data_byte = b;
    it.avail     = avail;
    return it;
  endfunction

  // Random data byte. Full-range avail only under a small cap, so that
  // chunks stay short and close often; otherwise mostly small counts.
  function automatic in_item_t random_byte_item();
    in_item_t it;
    it.func      = FUNC_DATA;
    it.data_byte = 8'($urandom);
    if (cap_now <= 16'd64 && $urandom_range(0, 1) == 1) begin
      it.avail = 16'($urandom);
    end else if ($urandom_range(0, 7) == 0) begin
      it.avail = '0;
    end else begin
      it.avail = 16'($urandom_range(1, 12));
    end
    return it;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  // Valid is only raised when the item goes out and then held until accepted.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (value == '0) begin
      cap_now = 16'd1;
    end else if (value > CHUNK_CAP) begin
      cap_now = CHUNK_CAP;
    end else begin
      cap_now = value;
    end
  endtask

  // Drop valid, wait for every expected byte, then give the block a few
  // cycles to finish anything that produces no output.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // One block of random data under a freshly drawn chunk limit.
  task automatic random_block(input int n_items);
    logic [15:0] setting;
    case ($urandom_range(0, 5))
      0: begin
        setting = 16'd0;
      end
      1: begin
        setting = 16'd1;
      end
      2: begin
        setting = 16'($urandom_range(2, 16));
      end
      3: begin
        setting = 16'($urandom_range(17, 64));
      end
      4: begin
        setting = CHUNK_CAP;
      end
      default: begin
        setting = 16'($urandom_range(32'h8001, 32'hffff));
      end
    endcase
    settle();
    write_max_len(setting);
    repeat (n_items) send_item(random_byte_item());
  endtask

  initial begin
    in_item_t it;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, still under the reset limit of 0x8000.
    // Zero available counts as one: header, byte and trailer, nine bytes.
    send_item(data_item(16'd0, 8'h00));
    send_item(data_item(16'd2, 8'hff));
    // Inside a chunk avail is ignored; this byte closes the chunk.
    send_item(data_item(16'hffff, 8'h5a));

    // A limit of zero behaves as one: every byte is its own chunk.
    settle();
    write_max_len(16'd0);
    send_item(data_item(16'hffff, 8'ha5));
    send_item(data_item(16'h8000, 8'h3c));

    settle();
    write_max_len(16'd1);
    send_item(data_item(16'd7, 8'h81));

    // Cap a large count down to three.
    settle();
    write_max_len(16'd3);
    send_item(data_item(16'hffff, 8'h11));
    send_item(data_item(16'd0, 8'h22));
    send_item(data_item(16'h1234, 8'h33));

    // Open a ten-byte chunk (letter digit in the header); the random
    // traffic below finishes it.
    settle();
    write_max_len(CHUNK_CAP);
    send_item(data_item(16'd10, 8'h7e));

    // Random traffic, phase one: slow receiver.
    repeat (3) random_block(16);

    // Phase two: slow sender.
    send_idle_pct = 82;
    recv_idle_pct = 18;
    repeat (3) random_block(16);

    // Phase three: no gaps on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) random_block(16);

    // A limit above 0x8000 clamps to it: header "8000". Close whatever chunk
    // the random traffic left open first. End of input then arrives while
    // the chunk still owes bytes: the chunk is abandoned and only the
    // terminator goes out.
    settle();
    write_max_len(16'hffff);
    while (chunk_open) send_item(random_byte_item());
    send_item(data_item(16'hc0de, 8'h01));
    repeat (6) send_item(random_byte_item());
    it      = random_byte_item();
    it.func = FUNC_END;
    send_item(it);

    // After the terminator every input is swallowed without output.
    repeat (4) begin
      it      = random_byte_item();
      it.func = logic'($urandom_range(0, 1));
      send_item(it);
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hce_pkg.sv
rtl/hce_framer.sv
rtl/hce_serializer.sv
rtl/http_chunked_encoder_core.sv
bench/chunk_coding_checker.sv
bench/http_chunked_encoder_core_tb.sv
